FILE: rtl/core/tlg_pkg.sv
// shared types and constants for the toroidal life generation core
package tlg_pkg;

    localparam int ACTION_W  = 2;
    localparam int COORD_W   = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;
    localparam int NBR_W     = 8;
    localparam int CNT_W     = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_IN_USE = 1'd0,
        REG_COLS_IN_USE = 1'd1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;
    localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;

endpackage

FILE: rtl/core/tlg_rule_unit.sv
// neighbor count and b3/s23 rule evaluation for one cell
module tlg_rule_unit (
    input  logic [tlg_pkg::NBR_W-1:0] nbr,
    input  logic                      self_live,
    output logic                      next_live
);
    import tlg_pkg::*;

    logic [CNT_W-1:0] count;

    always_comb begin
        count = '0;
        for (int i = 0; i < NBR_W; i++) begin
            count = count + CNT_W'(nbr[i]);
        end
    end

    always_comb begin
        if (count == SURVIVE_COUNT) begin
            next_live = self_live;
        end else if (count == BIRTH_COUNT) begin
            next_live = 1'b1;
        end else begin
            next_live = 1'b0;
        end
    end

endmodule

FILE: rtl/core/tlg_cell_mem.sv
// one-bit-per-cell grid memory with registered read
module tlg_cell_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);
    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/tlg_snap_mem.sv
// row-wide snapshot memory used during a generation
module tlg_snap_mem #(
    parameter int ROWS = 64,
    parameter int COLS = 64,
    parameter int RIW  = 6
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [RIW-1:0]  wr_row,
    input  logic [COLS-1:0] wr_data,
    input  logic            rd_en,
    input  logic [RIW-1:0]  rd_row,
    output logic [COLS-1:0] rd_data
);
    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/toroidal_life_generation_core.sv
// top level of the toroidal life generation core
// Holds a grid of up to MAX_ROWS x MAX_COLS one-bit cells and runs Conway
// generations (B3/S23) with wraparound over the rows and columns in use.
// A write, an out-of-range access or an unused action is answered from
// ST_IDLE; a read answers from ST_READ_RESP. A generation copies the region
// in use into the row-wide snapshot (ST_COPY, ST_COPY_DRAIN), then for each
// row loads the rows above, at and below it (ST_LOAD) and rebuilds it one
// cell per cycle through the single rule unit (ST_CALC), then posts the
// result (ST_FINISH); the one-bit-wide cell memory, read or written one cell
// per cycle, sets this pace. After reset a clearing pass over the whole grid
// runs with s_tready low. One item is in work at a time; the result register
// lets the next item in as soon as the previous result is taken.
module toroidal_life_generation_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // action[1:0], cell_row[7:2], cell_col[13:8], live_in[14], zero[15]
    input  logic [tlg_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // live_out[0], range_error[1], zero[7:2]
    output logic [tlg_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlg_pkg::CFG_W-1:0]         cfg_data
);
    import tlg_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RDW   = $clog2(MAX_ROWS + 1);
    localparam int CDW   = $clog2(MAX_COLS + 1);
    localparam int RCW   = (RDW > CFG_W) ? RDW : CFG_W;
    localparam int CCW   = (CDW > CFG_W) ? CDW : CFG_W;

    localparam logic [RIW-1:0] CLR_LAST_ROW = RIW'(MAX_ROWS - 1);
    localparam logic [CIW-1:0] CLR_LAST_COL = CIW'(MAX_COLS - 1);
    localparam logic [AW-1:0]  ROW_STRIDE   = AW'(MAX_COLS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_RESP,
        ST_COPY,
        ST_COPY_DRAIN,
        ST_LOAD,
        ST_CALC,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [RIW-1:0]   r_reg, r_next;
    logic [CIW-1:0]   c_reg, c_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [1:0]       ld_cnt_reg, ld_cnt_next;

    logic             cp_vld_reg, cp_vld_next;
    logic             cp_last_reg, cp_last_next;
    logic [CIW-1:0]   cp_col_reg, cp_col_next;
    logic [RIW-1:0]   cp_row_reg, cp_row_next;
    logic [MAX_COLS-1:0] row_buf_reg, row_fill;

    logic [MAX_COLS-1:0] up_reg, up_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic [MAX_COLS-1:0] dn_reg, dn_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic live_out_reg, live_out_next;
    logic range_error_reg, range_error_next;

    // effective dimensions
    logic [RCW-1:0] rows_ext;
    logic [CCW-1:0] cols_ext;
    logic [RDW-1:0] nr;
    logic [CDW-1:0] nc;
    logic [RIW-1:0] last_row;
    logic [CIW-1:0] last_col;

    always_comb begin
        rows_ext = RCW'(rows_cfg_reg);
        cols_ext = CCW'(cols_cfg_reg);
        if (rows_ext == '0) begin
            nr = RDW'(1);
        end else if (rows_ext > RCW'(MAX_ROWS)) begin
            nr = RDW'(MAX_ROWS);
        end else begin
            nr = RDW'(rows_ext);
        end
        if (cols_ext == '0) begin
            nc = CDW'(1);
        end else if (cols_ext > CCW'(MAX_COLS)) begin
            nc = CDW'(MAX_COLS);
        end else begin
            nc = CDW'(cols_ext);
        end
        last_row = RIW'(nr - RDW'(1));
        last_col = CIW'(nc - CDW'(1));
    end

    // input fields
    logic [ACTION_W-1:0] in_action;
    logic [COORD_W-1:0]  in_row, in_col;
    logic                in_live;
    logic                in_range_err;
    logic [AW-1:0]       acc_addr;

    assign in_action = s_tdata[1:0];
    assign in_row    = s_tdata[7:2];
    assign in_col    = s_tdata[13:8];
    assign in_live   = s_tdata[14];

    assign in_range_err = (RCW'(in_row) >= RCW'(nr)) || (CCW'(in_col) >= CCW'(nc));
    assign acc_addr     = AW'(RIW'(in_row)) * ROW_STRIDE + AW'(CIW'(in_col));

    logic slot_free, in_accept;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // sweep geometry
    logic [AW-1:0]  sweep_addr;
    logic [RIW-1:0] up_row, dn_row;
    logic [CIW-1:0] lf_col, rt_col;

    assign sweep_addr = base_reg + AW'(c_reg);
    assign up_row = (r_reg == '0) ? last_row : r_reg - RIW'(1);
    assign dn_row = (r_reg == last_row) ? '0 : r_reg + RIW'(1);
    assign lf_col = (c_reg == '0) ? last_col : c_reg - CIW'(1);
    assign rt_col = (c_reg == last_col) ? '0 : c_reg + CIW'(1);

    // memories and rule unit
    logic           cell_wr_en, cell_wr_data, cell_rd_en, cell_rd_data;
    logic [AW-1:0]  cell_wr_addr, cell_rd_addr;
    logic           snap_wr_en, snap_rd_en;
    logic [RIW-1:0] snap_rd_row;
    logic [MAX_COLS-1:0] snap_rd_data;
    logic [NBR_W-1:0] nbr;
    logic           next_live;

    tlg_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_mem (
        .aclk    (aclk),
        .wr_en   (cell_wr_en),
        .wr_addr (cell_wr_addr),
        .wr_data (cell_wr_data),
        .rd_en   (cell_rd_en),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    tlg_snap_mem #(
        .ROWS (MAX_ROWS),
        .COLS (MAX_COLS),
        .RIW  (RIW)
    ) u_snap_mem (
        .aclk    (aclk),
        .wr_en   (snap_wr_en),
        .wr_row  (cp_row_reg),
        .wr_data (row_fill),
        .rd_en   (snap_rd_en),
        .rd_row  (snap_rd_row),
        .rd_data (snap_rd_data)
    );

    assign nbr = {up_reg[lf_col], up_reg[c_reg], up_reg[rt_col],
                  cur_reg[lf_col], cur_reg[rt_col],
                  dn_reg[lf_col], dn_reg[c_reg], dn_reg[rt_col]};

    tlg_rule_unit u_rule_unit (
        .nbr       (nbr),
        .self_live (cur_reg[c_reg]),
        .next_live (next_live)
    );

    // copy pipeline row assembly
    always_comb begin
        row_fill = row_buf_reg;
        if (cp_vld_reg) begin
            row_fill[cp_col_reg] = cell_rd_data;
        end
    end
    assign snap_wr_en = cp_vld_reg && cp_last_reg;

    always_comb begin
        state_next       = state_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        base_next        = base_reg;
        ld_cnt_next      = ld_cnt_reg;
        cp_vld_next      = 1'b0;
        cp_last_next     = 1'b0;
        cp_col_next      = c_reg;
        cp_row_next      = r_reg;
        up_next          = up_reg;
        cur_next         = cur_reg;
        dn_next          = dn_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        live_out_next    = live_out_reg;
        range_error_next = range_error_reg;

        cell_wr_en   = 1'b0;
        cell_wr_addr = sweep_addr;
        cell_wr_data = 1'b0;
        cell_rd_en   = 1'b0;
        cell_rd_addr = sweep_addr;
        snap_rd_en   = 1'b0;
        snap_rd_row  = r_reg;

        case (state_reg)
            ST_CLEAR: begin
                cell_wr_en = 1'b1;
                if (c_reg == CLR_LAST_COL) begin
                    c_next = '0;
                    if (r_reg == CLR_LAST_ROW) begin
                        r_next     = '0;
                        base_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        r_next    = r_reg + RIW'(1);
                        base_next = base_reg + ROW_STRIDE;
                    end
                end else begin
                    c_next = c_reg + CIW'(1);
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_action)
                        ACT_WRITE, ACT_READ: begin
                            if (in_range_err) begin
                                m_tvalid_next    = 1'b1;
                                live_out_next    = 1'b0;
                                range_error_next = 1'b1;
                            end else if (in_action == ACT_WRITE) begin
                                cell_wr_en       = 1'b1;
                                cell_wr_addr     = acc_addr;
                                cell_wr_data     = in_live;
                                m_tvalid_next    = 1'b1;
                                live_out_next    = 1'b0;
                                range_error_next = 1'b0;
                            end else begin
                                cell_rd_en   = 1'b1;
                                cell_rd_addr = acc_addr;
                                state_next   = ST_READ_RESP;
                            end
                        end
                        ACT_TICK: begin
                            r_next     = '0;
                            c_next     = '0;
                            base_next  = '0;
                            state_next = ST_COPY;
                        end
                        default: begin
                            m_tvalid_next    = 1'b1;
                            live_out_next    = 1'b0;
                            range_error_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ_RESP: begin
                m_tvalid_next    = 1'b1;
                live_out_next    = cell_rd_data;
                range_error_next = 1'b0;
                state_next       = ST_IDLE;
            end
            ST_COPY: begin
                cell_rd_en   = 1'b1;
                cp_vld_next  = 1'b1;
                cp_last_next = (c_reg == last_col);
                if (c_reg == last_col) begin
                    c_next = '0;
                    if (r_reg == last_row) begin
                        r_next     = '0;
                        base_next  = '0;
                        state_next = ST_COPY_DRAIN;
                    end else begin
                        r_next    = r_reg + RIW'(1);
                        base_next = base_reg + ROW_STRIDE;
                    end
                end else begin
                    c_next = c_reg + CIW'(1);
                end
            end
            ST_COPY_DRAIN: begin
                ld_cnt_next = '0;
                state_next  = ST_LOAD;
            end
            ST_LOAD: begin
                snap_rd_en = (ld_cnt_reg != 2'd3);
                case (ld_cnt_reg)
                    2'd0: snap_rd_row = up_row;
                    2'd1: snap_rd_row = r_reg;
                    default: snap_rd_row = dn_row;
                endcase
                case (ld_cnt_reg)
                    2'd1: up_next  = snap_rd_data;
                    2'd2: cur_next = snap_rd_data;
                    2'd3: dn_next  = snap_rd_data;
                    default: up_next = up_reg;
                endcase
                ld_cnt_next = ld_cnt_reg + 2'd1;
                if (ld_cnt_reg == 2'd3) begin
                    c_next     = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cell_wr_en   = 1'b1;
                cell_wr_data = next_live;
                if (c_reg == last_col) begin
                    c_next = '0;
                    if (r_reg == last_row) begin
                        state_next = ST_FINISH;
                    end else begin
                        r_next      = r_reg + RIW'(1);
                        base_next   = base_reg + ROW_STRIDE;
                        ld_cnt_next = '0;
                        state_next  = ST_LOAD;
                    end
                end else begin
                    c_next = c_reg + CIW'(1);
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    m_tvalid_next    = 1'b1;
                    live_out_next    = 1'b0;
                    range_error_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            r_reg        <= '0;
            c_reg        <= '0;
            base_reg     <= '0;
            ld_cnt_reg   <= '0;
            cp_vld_reg   <= 1'b0;
            cp_last_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
        end else begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            base_reg     <= base_next;
            ld_cnt_reg   <= ld_cnt_next;
            cp_vld_reg   <= cp_vld_next;
            cp_last_reg  <= cp_last_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ROWS_IN_USE: rows_cfg_reg <= cfg_data;
                    REG_COLS_IN_USE: cols_cfg_reg <= cfg_data;
                    default: rows_cfg_reg <= rows_cfg_reg;
                endcase
            end
        end
        cp_col_reg      <= cp_col_next;
        cp_row_reg      <= cp_row_next;
        row_buf_reg     <= row_fill;
        up_reg          <= up_next;
        cur_reg         <= cur_next;
        dn_reg          <= dn_next;
        live_out_reg    <= live_out_next;
        range_error_reg <= range_error_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - 2){1'b0}}, range_error_reg, live_out_reg};

endmodule
